// ===== rtl/tcd_pkg.sv =====
// Shared types and constants for the tick count to calendar date converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package tcd_pkg;

    localparam int TICK_RATE = 40500000;
    localparam int TICK_W    = 63;
    localparam int RATE_W    = $clog2(TICK_RATE + 1);
    localparam int DIV_W     = (RATE_W > 18) ? RATE_W : 18;
    localparam int SECS_W    = 64 - RATE_W;
    localparam int PROD_W    = RATE_W + 20;
    localparam int DAY_W     = 22;
    localparam int CYCD_W    = 18;

    localparam logic [DAY_W-1:0] LIMIT_DAYS = 22'd2921940;
    localparam logic [16:0]      LAST_SOD   = 17'd86399;

    // floor(2^64 / d): quotient estimate is at most one below the true quotient
    function automatic logic [63:0] recip_of(input int unsigned d);
        return 64'((65'd1 << 64) / 65'(d));
    endfunction

    localparam logic [63:0] RECIP_RATE = recip_of(TICK_RATE);
    localparam logic [63:0] RECIP_DAY  = recip_of(86400);
    localparam logic [63:0] RECIP_MS   = recip_of(1000);
    localparam logic [63:0] RECIP_HOUR = recip_of(3600);
    localparam logic [63:0] RECIP_MIN  = recip_of(60);
    localparam logic [63:0] RECIP_CYC  = recip_of(146097);
    localparam logic [63:0] RECIP_WDAY = recip_of(7);

    typedef enum logic [2:0] {
        OP_TICK, OP_DAY, OP_FRAC, OP_MS, OP_HOUR, OP_MIN, OP_CYC, OP_WDAY
    } op_t;

    typedef struct packed {
        logic take;
        logic start;
        logic capture;
        logic year_step;
        logic publish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic year_done;
    } sts_t;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic op_t next_op(input op_t op);
        op_t r;
        unique case (op)
            OP_TICK: r = OP_DAY;
            OP_DAY:  r = OP_FRAC;
            OP_FRAC: r = OP_MS;
            OP_MS:   r = OP_HOUR;
            OP_HOUR: r = OP_MIN;
            OP_MIN:  r = OP_CYC;
            OP_CYC:  r = OP_WDAY;
            OP_WDAY: r = OP_TICK;
            default: r = OP_TICK;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tcd_div.sv =====
// Constant divider by reciprocal multiplication on one 32x32 multiplier, seven steps.
// Depends on tcd_pkg.
`default_nettype none
module tcd_div
    import tcd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    input  wire logic [63:0]       recip,
    output logic                   done,
    output logic [TICK_W-1:0]      quotient,
    output logic [DIV_W-1:0]       remainder
);
    typedef enum logic [7:0] {
        PH_IDLE = 8'b00000001,
        PH_LL   = 8'b00000010,
        PH_LH   = 8'b00000100,
        PH_HL   = 8'b00001000,
        PH_HH   = 8'b00010000,
        PH_QL   = 8'b00100000,
        PH_QH   = 8'b01000000,
        PH_FIX  = 8'b10000000
    } phase_t;

    phase_t            ph_reg, ph_next;
    logic [63:0]       x_reg, x_next;
    logic [63:0]       m_reg, m_next;
    logic [DIV_W-1:0]  d_reg, d_next;
    logic [127:0]      acc_reg, acc_next;
    logic [63:0]       q_reg, q_next;
    logic [63:0]       r_reg, r_next;
    logic              done_reg, done_next;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = x_reg[31:0];
        mul_b = m_reg[31:0];
        unique case (ph_reg)
            PH_LH:
            begin
                mul_a = x_reg[31:0];
                mul_b = m_reg[63:32];
            end
            PH_HL:
            begin
                mul_a = x_reg[63:32];
                mul_b = m_reg[31:0];
            end
            PH_HH:
            begin
                mul_a = x_reg[63:32];
                mul_b = m_reg[63:32];
            end
            PH_QL:
            begin
                mul_a = q_reg[31:0];
                mul_b = 32'(d_reg);
            end
            PH_QH:
            begin
                mul_a = q_reg[63:32];
                mul_b = 32'(d_reg);
            end
            default:
            begin
                mul_a = x_reg[31:0];
                mul_b = m_reg[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        ph_next   = ph_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        d_next    = d_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        done_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    x_next  = 64'(dividend);
                    m_next  = recip;
                    d_next  = divisor;
                    ph_next = PH_LL;
                end
            end
            PH_LL:
            begin
                acc_next = {64'd0, prod};
                ph_next  = PH_LH;
            end
            PH_LH:
            begin
                acc_next = acc_reg + {32'd0, prod, 32'd0};
                ph_next  = PH_HL;
            end
            PH_HL:
            begin
                acc_next = acc_reg + {32'd0, prod, 32'd0};
                ph_next  = PH_HH;
            end
            PH_HH:
            begin
                // high half of dividend times reciprocal: quotient or one less
                q_next  = acc_reg[127:64] + prod;
                ph_next = PH_QL;
            end
            PH_QL:
            begin
                r_next  = x_reg - prod;
                ph_next = PH_QH;
            end
            PH_QH:
            begin
                r_next  = r_reg - {prod[31:0], 32'd0};
                ph_next = PH_FIX;
            end
            PH_FIX:
            begin
                if (r_reg >= 64'(d_reg))
                begin
                    q_next = q_reg + 64'd1;
                    r_next = r_reg - 64'(d_reg);
                end
                done_next = 1'b1;
                ph_next   = PH_IDLE;
            end
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        m_reg   <= m_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg[TICK_W-1:0];
    assign remainder = r_reg[DIV_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/tcd_datapath.sv =====
// Datapath: operand selection, divider, year stepping, month lookup, result registers.
// Depends on tcd_pkg and tcd_div.
`default_nettype none
module tcd_datapath
    import tcd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [TICK_W-1:0] tick_count,
    output logic [9:0]             micro_in_milli,
    output logic [9:0]             millis,
    output logic [5:0]             seconds,
    output logic [5:0]             minutes,
    output logic [4:0]             hours,
    output logic [4:0]             day_of_month,
    output logic [3:0]             month_index,
    output logic [13:0]            year_number,
    output logic [2:0]             weekday,
    output logic [8:0]             day_of_year
);
    logic [TICK_W-1:0] tick_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [RATE_W-1:0] frac_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DAY_W-1:0]  days_reg;
    logic [16:0]       sod_reg;
    logic              sat_reg;
    logic [19:0]       q1_reg;
    logic [9:0]        usec_reg, msec_reg;
    logic [4:0]        hour_reg;
    logic [11:0]       hrem_reg;
    logic [5:0]        min_reg, sec_reg;
    logic [2:0]        wday_reg;
    logic [CYCD_W-1:0] dcyc_reg;
    logic [13:0]       year_reg;
    logic [1:0]        y4_reg;
    logic [6:0]        y100_reg;
    logic [8:0]        y400_reg;

    logic [TICK_W-1:0] dvd;
    logic [DIV_W-1:0]  dsr;
    logic [63:0]       recip;
    logic              div_done;
    logic [TICK_W-1:0] quo;
    logic [DIV_W-1:0]  rem;

    logic              leap;
    logic [8:0]        year_len;
    logic [3:0]        mon;
    logic [8:0]        mstart;
    logic [8:0]        yday;

    always_comb
    begin
        unique case (cmd.op)
            OP_TICK:
            begin
                dvd   = tick_reg;
                dsr   = DIV_W'(TICK_RATE);
                recip = RECIP_RATE;
            end
            OP_DAY:
            begin
                dvd   = TICK_W'(secs_reg);
                dsr   = DIV_W'(86400);
                recip = RECIP_DAY;
            end
            OP_FRAC:
            begin
                dvd   = TICK_W'(prod_reg);
                dsr   = DIV_W'(TICK_RATE);
                recip = RECIP_RATE;
            end
            OP_MS:
            begin
                dvd   = TICK_W'(q1_reg);
                dsr   = DIV_W'(1000);
                recip = RECIP_MS;
            end
            OP_HOUR:
            begin
                dvd   = TICK_W'(sod_reg);
                dsr   = DIV_W'(3600);
                recip = RECIP_HOUR;
            end
            OP_MIN:
            begin
                dvd   = TICK_W'(hrem_reg);
                dsr   = DIV_W'(60);
                recip = RECIP_MIN;
            end
            OP_CYC:
            begin
                dvd   = TICK_W'(days_reg);
                dsr   = DIV_W'(146097);
                recip = RECIP_CYC;
            end
            OP_WDAY:
            begin
                dvd   = TICK_W'(days_reg) + TICK_W'(6);
                dsr   = DIV_W'(7);
                recip = RECIP_WDAY;
            end
            default:
            begin
                dvd   = tick_reg;
                dsr   = DIV_W'(TICK_RATE);
                recip = RECIP_RATE;
            end
        endcase
    end

    tcd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (dvd),
        .divisor   (dsr),
        .recip     (recip),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign leap     = ((y4_reg == 2'd0) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign yday     = dcyc_reg[8:0];

    // pick the last month whose start the day has reached
    always_comb
    begin
        mon    = 4'd0;
        mstart = 9'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (yday >= MONTH_START[m] + ((m > 1 && leap) ? 9'd1 : 9'd0))
            begin
                mon    = 4'(m);
                mstart = MONTH_START[m] + ((m > 1 && leap) ? 9'd1 : 9'd0);
            end
        end
    end

    assign sts.div_done  = div_done;
    assign sts.year_done = (dcyc_reg < CYCD_W'(year_len));

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(frac_reg) * PROD_W'(1000000);
        if (cmd.take)
            tick_reg <= tick_count;
        if (cmd.capture)
        begin
            unique case (cmd.op)
                OP_TICK:
                begin
                    secs_reg <= quo[SECS_W-1:0];
                    frac_reg <= rem[RATE_W-1:0];
                end
                OP_DAY:
                begin
                    if (quo >= TICK_W'(LIMIT_DAYS))
                    begin
                        days_reg <= LIMIT_DAYS - DAY_W'(1);
                        sod_reg  <= LAST_SOD;
                        sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        days_reg <= quo[DAY_W-1:0];
                        sod_reg  <= rem[16:0];
                        sat_reg  <= 1'b0;
                    end
                end
                OP_FRAC: q1_reg <= quo[19:0];
                OP_MS:
                begin
                    msec_reg <= quo[9:0];
                    usec_reg <= rem[9:0];
                end
                OP_HOUR:
                begin
                    hour_reg <= quo[4:0];
                    hrem_reg <= rem[11:0];
                end
                OP_MIN:
                begin
                    min_reg <= quo[5:0];
                    sec_reg <= rem[5:0];
                end
                OP_CYC:
                begin
                    year_reg <= 14'd2000 + 14'(quo[4:0]) * 14'd400;
                    dcyc_reg <= rem[CYCD_W-1:0];
                    y4_reg   <= 2'd0;
                    y100_reg <= 7'd0;
                    y400_reg <= 9'd0;
                end
                OP_WDAY: wday_reg <= rem[2:0];
                default: ;
            endcase
        end
        if (cmd.year_step)
        begin
            dcyc_reg <= dcyc_reg - CYCD_W'(year_len);
            year_reg <= year_reg + 14'd1;
            y4_reg   <= y4_reg + 2'd1;
            y100_reg <= (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
            y400_reg <= (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
        end
        if (cmd.publish)
        begin
            micro_in_milli <= sat_reg ? 10'd999 : usec_reg;
            millis         <= sat_reg ? 10'd999 : msec_reg;
            seconds        <= sec_reg;
            minutes        <= min_reg;
            hours          <= hour_reg;
            day_of_month   <= 5'(yday - mstart + 9'd1);
            month_index    <= mon;
            year_number    <= year_reg;
            weekday        <= wday_reg;
            day_of_year    <= yday;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tcd_ctrl.sv =====
// Controller: sequences the divisions, the year stepping and the output transfer.
// Depends on tcd_pkg.
`default_nettype none
module tcd_ctrl
    import tcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_WAIT   = 5'b00100,
        ST_YEAR   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.op      = op_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    op_next    = OP_TICK;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    op_next     = next_op(op_reg);
                    state_next  = (op_reg == OP_WDAY) ? ST_YEAR : ST_LOAD;
                end
            end
            ST_YEAR:
            begin
                if (sts.year_done)
                    state_next = ST_FINISH;
                else
                    cmd.year_step = 1'b1;
            end
            ST_FINISH:
            begin
                // hold until the previous result has been transferred
                if (!ovalid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_TICK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
endmodule
`default_nettype wire

// ===== rtl/ticks_to_calendar_date.sv =====
// Top level of the tick count to calendar date converter.
// Depends on tcd_pkg, tcd_ctrl, tcd_datapath.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   tick_count
//   output   out_valid / out_ready micro_in_milli .. day_of_year
//
// One item is taken in one transfer, then runs eight constant divisions
// (start, seven multiply and correct steps on one 32x32 multiplier, capture),
// steps one year at a time inside the 400-year cycle (0..399), ends the year
// search and publishes.
// Reset clears the controller; datapath registers are loaded before use.
// A finished result waits in the output register while the next item runs;
// the next item stalls in its publish cycle until that result is transferred.
`default_nettype none
module ticks_to_calendar_date
    import tcd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [TICK_W-1:0] tick_count,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [9:0]             micro_in_milli,
    output logic [9:0]             millis,
    output logic [5:0]             seconds,
    output logic [5:0]             minutes,
    output logic [4:0]             hours,
    output logic [4:0]             day_of_month,
    output logic [3:0]             month_index,
    output logic [13:0]            year_number,
    output logic [2:0]             weekday,
    output logic [8:0]             day_of_year
);
    cmd_t cmd;
    sts_t sts;

    tcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tcd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .tick_count     (tick_count),
        .micro_in_milli (micro_in_milli),
        .millis         (millis),
        .seconds        (seconds),
        .minutes        (minutes),
        .hours          (hours),
        .day_of_month   (day_of_month),
        .month_index    (month_index),
        .year_number    (year_number),
        .weekday        (weekday),
        .day_of_year    (day_of_year)
    );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for ticks_to_calendar_date.
// Depends on tcd_pkg and the RTL; a built-in date predictor checks every transfer.
`timescale 1ns / 100ps
module tb_top;
    import tcd_pkg::*;

    localparam longint unsigned RATE      = 64'(TICK_RATE);
    localparam longint unsigned DAY_TICKS = RATE * 64'd86400;
    localparam int              MAX_CYC   = 3000000;
    localparam int              HOLD_CYC  = 3000;

    typedef struct packed {
        logic [9:0]  micro_in_milli;
        logic [9:0]  millis;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  day_of_month;
        logic [3:0]  month_index;
        logic [13:0] year_number;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } date_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [TICK_W-1:0] tick_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    date_t             got;

    logic [TICK_W-1:0] pending_ticks[$];
    date_t             expected_dates[$];
    int                cycle_cnt = 0;
    int                n_fail = 0;
    int                n_in = 0;
    int                n_out = 0;
    bit                hold_req = 1'b0;
    bit                holding = 1'b0;

    always #5 clk = ~clk;

    ticks_to_calendar_date DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .tick_count(tick_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .micro_in_milli(got.micro_in_milli), .millis(got.millis),
        .seconds(got.seconds), .minutes(got.minutes), .hours(got.hours),
        .day_of_month(got.day_of_month), .month_index(got.month_index),
        .year_number(got.year_number), .weekday(got.weekday),
        .day_of_year(got.day_of_year)
    );

    function automatic bit is_leap(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic date_t civil_date(input logic [TICK_W-1:0] t);
        longint unsigned ticks, secs, rem, usec, msec, days, sod;
        int    year, mon, len, adj;
        bit    leap;
        date_t d;
        ticks = 64'(t);
        secs  = ticks / RATE;
        rem   = ticks - secs * RATE;
        usec  = ((rem * 64'd1000000) / RATE) % 64'd1000;
        msec  = (rem * 64'd1000) / RATE;
        days  = secs / 64'd86400;
        sod   = secs - days * 64'd86400;
        if (days >= 64'(LIMIT_DAYS))
        begin
            // saturate to the last instant of 9999
            usec = 999;
            msec = 999;
            sod  = 86399;
            days = 64'(LIMIT_DAYS) - 1;
        end
        d.weekday = 3'((days + 6) % 7);
        year = 2000 + 400 * int'(days / 64'd146097);
        days = days % 64'd146097;
        forever
        begin
            len = is_leap(year) ? 366 : 365;
            if (days < 64'(len))
                break;
            days -= 64'(len);
            year++;
        end
        leap = is_leap(year);
        mon = 11;
        forever
        begin
            adj = (mon > 1 && leap) ? 1 : 0;
            if (mon == 0 || days >= 64'(MONTH_START[mon] + adj))
                break;
            mon--;
        end
        adj = (mon > 1 && leap) ? 1 : 0;
        d.micro_in_milli = 10'(usec);
        d.millis         = 10'(msec);
        d.seconds        = 6'(sod % 60);
        d.minutes        = 6'((sod / 60) % 60);
        d.hours          = 5'(sod / 3600);
        d.day_of_month   = 5'(days - 64'(MONTH_START[mon]) - 64'(adj) + 1);
        d.month_index    = 4'(mon);
        d.year_number    = 14'(year);
        d.weekday        = d.weekday;
        d.day_of_year    = 9'(days);
        return d;
    endfunction

    // No-idle window in the middle of the run
    function automatic bit take_break();
        if (n_in >= 200 && n_in < 350)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    // Sender
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pending_ticks.size() > 0 && !take_break())
            begin
                in_valid   <= 1'b1;
                tick_count <= pending_ticks.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver, with one long hold-off
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !holding)
            begin
                holding   <= 1'b1;
                hold_left <= HOLD_CYC;
                out_ready <= 1'b0;
            end
            else if (holding && hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !take_break();
        end
    end

    // Monitor: log input transfers, check output transfers
    always @(posedge clk)
    begin
        date_t e;
        cycle_cnt <= cycle_cnt + 1;
        if (in_valid && in_ready)
        begin
            expected_dates.push_back(civil_date(tick_count));
            n_in <= n_in + 1;
        end
        if (out_valid && out_ready)
        begin
            n_out <= n_out + 1;
            if (expected_dates.size() == 0)
            begin
                $error("result with nothing expected");
                n_fail <= n_fail + 1;
            end
            else
            begin
                e = expected_dates.pop_front();
                if (got !== e)
                begin
                    n_fail <= n_fail + 1;
                    if (got.micro_in_milli !== e.micro_in_milli)
                        $error("micro_in_milli exp %0d got %0d", e.micro_in_milli,
                               got.micro_in_milli);
                    if (got.millis !== e.millis)
                        $error("millis exp %0d got %0d", e.millis, got.millis);
                    if (got.seconds !== e.seconds)
                        $error("seconds exp %0d got %0d", e.seconds, got.seconds);
                    if (got.minutes !== e.minutes)
                        $error("minutes exp %0d got %0d", e.minutes, got.minutes);
                    if (got.hours !== e.hours)
                        $error("hours exp %0d got %0d", e.hours, got.hours);
                    if (got.day_of_month !== e.day_of_month)
                        $error("day_of_month exp %0d got %0d", e.day_of_month,
                               got.day_of_month);
                    if (got.month_index !== e.month_index)
                        $error("month_index exp %0d got %0d", e.month_index,
                               got.month_index);
                    if (got.year_number !== e.year_number)
                        $error("year_number exp %0d got %0d", e.year_number,
                               got.year_number);
                    if (got.weekday !== e.weekday)
                        $error("weekday exp %0d got %0d", e.weekday, got.weekday);
                    if (got.day_of_year !== e.day_of_year)
                        $error("day_of_year exp %0d got %0d", e.day_of_year,
                               got.day_of_year);
                end
            end
        end
        if (cycle_cnt >= MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [TICK_W-1:0] at_day(input longint unsigned d,
                                                 input longint unsigned frac);
        return TICK_W'(d * DAY_TICKS + frac);
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks();
        longint unsigned v;
        v = {$urandom, $urandom};
        return TICK_W'(v);
    endfunction

    initial
    begin
        longint unsigned d;
        // directed: extremes, second/day/leap/century edges
        pending_ticks.push_back('0);
        pending_ticks.push_back('1);
        pending_ticks.push_back(TICK_W'(RATE - 1));
        pending_ticks.push_back(TICK_W'(RATE));
        pending_ticks.push_back(TICK_W'(RATE / 1000 - 1));
        pending_ticks.push_back(TICK_W'(RATE / 1000000));
        pending_ticks.push_back(at_day(1, 0) - 1);
        pending_ticks.push_back(at_day(1, 0));
        pending_ticks.push_back(at_day(58, 0));
        pending_ticks.push_back(at_day(59, 0));          // 2000-02-29
        pending_ticks.push_back(at_day(60, 0));
        pending_ticks.push_back(at_day(365, 0));         // 2000-12-31
        pending_ticks.push_back(at_day(366, 0));
        pending_ticks.push_back(at_day(366 + 59, 0));    // 2001-03-01
        pending_ticks.push_back(at_day(36524 + 59, 0));  // 2100-02-28, no leap day
        pending_ticks.push_back(at_day(36525, 0));
        pending_ticks.push_back(at_day(146096, DAY_TICKS - 1));
        pending_ticks.push_back(at_day(146097, 0));      // 2400-01-01
        pending_ticks.push_back(at_day(146097 + 59, 0)); // 2400-02-29
        pending_ticks.push_back({1'b0, {(TICK_W-1){1'b1}}});
        pending_ticks.push_back({TICK_W{1'b1}});
        pending_ticks.push_back({1'b1, {(TICK_W-1){1'b0}}});
        for (int i = 0; i < 550; i++)
        begin
            case ($urandom_range(3))
                0: pending_ticks.push_back(rand_ticks());
                1: pending_ticks.push_back(rand_ticks() >> $urandom_range(62));
                default:
                begin
                    // random day, or one rounded down to a multiple of 365 near a year start
                    d = $urandom_range(2600000);
                    d = d - (d % 146097) + 64'($urandom_range(146096));
                    if ($urandom_range(1))
                        d = d - (d % 365);
                    pending_ticks.push_back(at_day(d, 64'($urandom_range(1))
                                                      * (DAY_TICKS - 1)));
                end
            endcase
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (n_in < 30) @(posedge clk);
        hold_req = 1'b1;

        while (pending_ticks.size() > 0 || in_valid) @(posedge clk);
        while (expected_dates.size() > 0) @(posedge clk);
        repeat (1000) @(posedge clk);

        $display("converted %0d tick counts into %0d checked dates", n_in, n_out);
        $display("covered leap/century edges, full 63-bit range and a long output stall");
        if (n_fail == 0 && expected_dates.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/tcd_pkg.sv
rtl/tcd_div.sv
rtl/tcd_datapath.sv
rtl/tcd_ctrl.sv
rtl/ticks_to_calendar_date.sv
dv/tb_top.sv
